// ----- design/dgf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and defaults of the Deriche gradient filter.
// Used by dgf_core and deriche_gradient_filter; depends on nothing.
package dgf_pkg;

  localparam int CFG_SIZE_W = 9;
  localparam int COEF_W = 24;
  localparam int PIX_W = 16;
  localparam int SAMP_W = 48;
  localparam int GRAD_W = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS = 16;
  localparam int CFG_SIZE_RESET = 256;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_PENDING = 2'd1,
    STAT_SMALL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_SMOOTH_A = 3'd2,
    REG_SMOOTH_B = 3'd3,
    REG_DERIV    = 3'd4,
    REG_FB_ONE   = 3'd5,
    REG_FB_TWO   = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PREP0,
    CS_PREP1,
    CS_PREP2,
    CS_READ,
    CS_MAC,
    CS_FIN,
    CS_WB
  } core_state_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] smooth_a;
    logic signed [COEF_W-1:0] smooth_b;
    logic signed [COEF_W-1:0] deriv;
    logic signed [COEF_W-1:0] fb_one;
    logic signed [COEF_W-1:0] fb_two;
  } coef_t;

endpackage

// ----- design/deriche_gradient_filter.sv -----
`timescale 1ns / 1ps
// Top level of the Deriche gradient filter: register port, frame load and result pull control.
// Depends on dgf_pkg and dgf_core.
//
// A transaction is accepted when start is high and busy is low. With mode_i at 0 it
// loads pixel_i as the next pixel of the frame in raster order, one per cycle, and
// produces no result. With mode_i at 1 it pulls one result: in the next cycle done_o is
// high for exactly one cycle with deriv_down_o, deriv_across_o, last_o and status_o.
// Pulls may follow each other in every cycle; the receiver cannot hold results off.
// When the last pixel of a frame of at least 2 x 2 arrives, busy rises for the whole
// computation: coefficient setup, then two phases of four recursive passes (causal and
// anticausal along rows, then along columns). Each sample of each pass goes through
// a memory read, four multiply-accumulate steps, rounding and write back. All passes
// share one multiply-accumulate unit, so samples are processed one at a time.
// Frame size is taken at the first pixel of a frame; gains are read live while computing.
// Reset clears the counters, so a pull reports a pending or too-small frame status.
// The user must write registers via the APB port only while idle; this is not enforced.
module deriche_gradient_filter #(
  parameter int MAX_WIDTH = dgf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dgf_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = dgf_pkg::DEF_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   mode_i,
  input  logic [dgf_pkg::PIX_W-1:0]              pixel_i,
  output logic                                   done_o,
  output logic signed [dgf_pkg::GRAD_W-1:0]      deriv_down_o,
  output logic signed [dgf_pkg::GRAD_W-1:0]      deriv_across_o,
  output logic                                   last_o,
  output logic [1:0]                             status_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dgf_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [dgf_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [dgf_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import dgf_pkg::*;

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(NPIX);
  localparam int CNTW = $clog2(NPIX + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int LAT_W_RST = (MAX_WIDTH < CFG_SIZE_RESET) ? MAX_WIDTH : CFG_SIZE_RESET;
  localparam int LAT_H_RST = (MAX_HEIGHT < CFG_SIZE_RESET) ? MAX_HEIGHT : CFG_SIZE_RESET;

  logic [CFG_SIZE_W-1:0] width_q, height_q;
  coef_t                 coef_q;
  reg_idx_e              reg_idx;
  logic                  cfg_wr;

  logic [CNTW-1:0] load_cnt_q, read_cnt_q, total_q;
  logic            frame_ready_q;
  logic [WW-1:0]   lat_w_q;
  logic [HW-1:0]   lat_h_q;
  logic            done_q, ok_q, last_q;
  status_e         status_q;

  logic            accept, do_load, do_pull, go;
  logic [WW-1:0]   eff_w, lw, pw;
  logic [HW-1:0]   eff_h, lh, ph;
  logic [CNTW-1:0] ld_cnt, ld_next, ld_total, rd_next;
  logic            ld_done, size_ok;
  status_e         pull_status;

  logic signed [GRAD_W-1:0] core_down, core_across;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= CFG_SIZE_W'(CFG_SIZE_RESET);
      height_q <= CFG_SIZE_W'(CFG_SIZE_RESET);
      coef_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:    width_q <= pwdata[CFG_SIZE_W-1:0];
        REG_HEIGHT:   height_q <= pwdata[CFG_SIZE_W-1:0];
        REG_SMOOTH_A: coef_q.smooth_a <= pwdata[COEF_W-1:0];
        REG_SMOOTH_B: coef_q.smooth_b <= pwdata[COEF_W-1:0];
        REG_DERIV:    coef_q.deriv <= pwdata[COEF_W-1:0];
        REG_FB_ONE:   coef_q.fb_one <= pwdata[COEF_W-1:0];
        REG_FB_TWO:   coef_q.fb_two <= pwdata[COEF_W-1:0];
        default:      width_q <= width_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:    prdata = APB_DATA_W'(width_q);
      REG_HEIGHT:   prdata = APB_DATA_W'(height_q);
      REG_SMOOTH_A: prdata = APB_DATA_W'(unsigned'(coef_q.smooth_a));
      REG_SMOOTH_B: prdata = APB_DATA_W'(unsigned'(coef_q.smooth_b));
      REG_DERIV:    prdata = APB_DATA_W'(unsigned'(coef_q.deriv));
      REG_FB_ONE:   prdata = APB_DATA_W'(unsigned'(coef_q.fb_one));
      REG_FB_TWO:   prdata = APB_DATA_W'(unsigned'(coef_q.fb_two));
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    accept = start & ~busy;
    do_load = accept & ~mode_i;
    do_pull = accept & mode_i;
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
    ld_cnt = frame_ready_q ? '0 : load_cnt_q;
    lw = (ld_cnt == '0) ? eff_w : lat_w_q;
    lh = (ld_cnt == '0) ? eff_h : lat_h_q;
    ld_total = CNTW'(lw) * CNTW'(lh);
    ld_next = ld_cnt + CNTW'(1);
    ld_done = (ld_next >= ld_total);
    size_ok = (lw >= WW'(2)) && (lh >= HW'(2));
    go = do_load & ld_done & size_ok;
    rd_next = read_cnt_q + CNTW'(1);
    pw = (load_cnt_q != '0) ? lat_w_q : eff_w;
    ph = (load_cnt_q != '0) ? lat_h_q : eff_h;
    pull_status = ((pw < WW'(2)) || (ph < HW'(2))) ? STAT_SMALL : STAT_PENDING;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      total_q <= CNTW'(LAT_W_RST * LAT_H_RST);
      frame_ready_q <= 1'b0;
      lat_w_q <= WW'(LAT_W_RST);
      lat_h_q <= HW'(LAT_H_RST);
      done_q <= 1'b0;
      ok_q <= 1'b0;
      last_q <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      done_q <= do_pull;
      if (do_load) begin
        lat_w_q <= lw;
        lat_h_q <= lh;
        total_q <= ld_total;
        read_cnt_q <= '0;
        frame_ready_q <= go;
        load_cnt_q <= (ld_done && !size_ok) ? '0 : ld_next;
      end
      if (do_pull) begin
        ok_q <= frame_ready_q;
        last_q <= frame_ready_q & (rd_next == total_q);
        status_q <= frame_ready_q ? STAT_OK : pull_status;
        if (frame_ready_q) begin
          if (rd_next >= total_q) begin
            frame_ready_q <= 1'b0;
            load_cnt_q <= '0;
            read_cnt_q <= '0;
          end else begin
            read_cnt_q <= rd_next;
          end
        end
      end
    end
  end

  dgf_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (go),
    .width_i       (lat_w_q),
    .height_i      (lat_h_q),
    .coef_i        (coef_q),
    .pix_we_i      (do_load),
    .pix_addr_i    (ld_cnt[AW-1:0]),
    .pix_data_i    (pixel_i),
    .grad_addr_i   (read_cnt_q[AW-1:0]),
    .deriv_down_o  (core_down),
    .deriv_across_o(core_across),
    .busy_o        (busy)
  );

  assign done_o = done_q;
  assign deriv_down_o = ok_q ? core_down : '0;
  assign deriv_across_o = ok_q ? core_across : '0;
  assign last_o = last_q;
  assign status_o = status_q;

  a_go_starts_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> busy)
    else $error("core did not start after a completed frame");

  a_busy_from_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(go))
    else $error("core became busy without a completed frame");

  a_read_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_ready_q |-> (read_cnt_q < total_q))
    else $error("read position ran past the frame");

  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && last_o) |-> (status_o == STAT_OK))
    else $error("last pixel marked on a result without ok status");

endmodule

// ----- design/dgf_core.sv -----
`timescale 1ns / 1ps
// Frame memories and the recursion sequencer with its shared multiply-accumulate unit.
// Depends on dgf_pkg.
module dgf_core #(
  parameter int MAX_WIDTH = dgf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dgf_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS = dgf_pkg::DEF_FRAC_BITS,
  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW = $clog2(NPIX),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  go_i,
  input  logic [WW-1:0]                         width_i,
  input  logic [HW-1:0]                         height_i,
  input  dgf_pkg::coef_t                        coef_i,
  input  logic                                  pix_we_i,
  input  logic [AW-1:0]                         pix_addr_i,
  input  logic [dgf_pkg::PIX_W-1:0]             pix_data_i,
  input  logic [AW-1:0]                         grad_addr_i,
  output logic signed [dgf_pkg::GRAD_W-1:0]     deriv_down_o,
  output logic signed [dgf_pkg::GRAD_W-1:0]     deriv_across_o,
  output logic                                  busy_o
);
  import dgf_pkg::*;

  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LW = $clog2(MAXD + 1);
  localparam int MC_W = COEF_W + 1;
  localparam int PL_W = 2 * MC_W;
  localparam int PH_W = MC_W + COEF_W;
  localparam int AL_W = PL_W + 2;
  localparam int AH_W = PH_W + 2;
  localparam int T_W = 76;
  localparam logic signed [AL_W-1:0] RND_ACC = AL_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PL_W-1:0] RND_PROD = PL_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SAMP_W+1:0] RND_SUM = (SAMP_W + 2)'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [T_W-1:0] clip(input logic signed [T_W-1:0] v,
                                                  input int unsigned bits);
    logic signed [T_W-1:0] hi;
    logic signed [T_W-1:0] lo;
    hi = (T_W'(1) <<< (bits - 1)) - T_W'(1);
    lo = -hi - T_W'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  logic [PIX_W-1:0]         pix_mem [NPIX];
  logic signed [SAMP_W-1:0] row_mem [NPIX];
  logic signed [SAMP_W-1:0] col_mem [NPIX];
  logic signed [GRAD_W-1:0] gdn_mem [NPIX];
  logic signed [GRAD_W-1:0] gac_mem [NPIX];

  logic [PIX_W-1:0]         pix_rd_q;
  logic signed [SAMP_W-1:0] row_rd_q, col_rd_q;
  logic signed [GRAD_W-1:0] gdn_rd_q, gac_rd_q;

  core_state_e state_q, state_d;
  logic          phase_q, colpass_q, anti_q;
  logic [1:0]    k_q;
  logic [LW-1:0] line_q, j_q;
  logic [AW-1:0] base_q, addr_q;

  logic signed [COEF_W-1:0] a3_q, a4_q;
  logic signed [PL_W-1:0]   prod_q;
  logic signed [SAMP_W-1:0] xa_q, xb_q, ya_q, yb_q, res_q;
  logic signed [AL_W-1:0]   acc_lo_q;
  logic signed [AH_W-1:0]   acc_hi_q;

  logic                     smooth;
  logic signed [MC_W-1:0]   a1e, a2e, ke, c0, c1, d1, d2, coef;
  logic signed [SAMP_W-1:0] fetch, samp;
  logic signed [MC_W-1:0]   m_a, m_b;
  logic signed [PL_W-1:0]   prod_lo;
  logic signed [PH_W-1:0]   prod_hi;
  logic signed [T_W-1:0]    t_sum;
  logic signed [SAMP_W-1:0] y_new;
  logic signed [PL_W-1:0]   prod_rnd;
  logic signed [SAMP_W:0]   row_sum;
  logic signed [SAMP_W+1:0] col_sum;
  logic signed [SAMP_W-1:0] row_wd;
  logic signed [GRAD_W-1:0] grad_wd;
  logic                     row_we, col_we, gdn_we, gac_we;
  logic [LW-1:0]            n_len, n_lines;
  logic                     last_step, last_line;
  logic [AW-1:0]            stride, lstride;

  always_ff @(posedge clk_i) begin
    if (pix_we_i) begin
      pix_mem[pix_addr_i] <= pix_data_i;
    end
    pix_rd_q <= pix_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[addr_q] <= row_wd;
    end
    row_rd_q <= row_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[addr_q] <= res_q;
    end
    col_rd_q <= col_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (gdn_we) begin
      gdn_mem[addr_q] <= grad_wd;
    end
    gdn_rd_q <= gdn_mem[grad_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (gac_we) begin
      gac_mem[addr_q] <= grad_wd;
    end
    gac_rd_q <= gac_mem[grad_addr_i];
  end

  assign deriv_down_o = gdn_rd_q;
  assign deriv_across_o = gac_rd_q;

  always_comb begin
    smooth = ~(phase_q ^ colpass_q);
    a1e = MC_W'(coef_i.smooth_a);
    a2e = MC_W'(coef_i.smooth_b);
    ke = MC_W'(coef_i.deriv);
    c0 = smooth ? a1e : '0;
    c1 = smooth ? a2e : ke;
    d1 = smooth ? MC_W'(a3_q) : -ke;
    d2 = smooth ? MC_W'(a4_q) : '0;
    fetch = colpass_q ? row_rd_q : signed'(SAMP_W'(pix_rd_q) << FRAC_BITS);
    case (k_q)
      2'd0: begin
        coef = anti_q ? d1 : c0;
        samp = anti_q ? xa_q : fetch;
      end
      2'd1: begin
        coef = anti_q ? d2 : c1;
        samp = anti_q ? xb_q : xa_q;
      end
      2'd2: begin
        coef = -MC_W'(coef_i.fb_one);
        samp = ya_q;
      end
      default: begin
        coef = -MC_W'(coef_i.fb_two);
        samp = yb_q;
      end
    endcase
    if (state_q == CS_PREP0) begin
      m_a = a1e;
      m_b = MC_W'(coef_i.fb_one);
    end else if (state_q == CS_PREP1) begin
      m_a = a1e;
      m_b = MC_W'(coef_i.fb_two);
    end else begin
      m_a = coef;
      m_b = signed'({1'b0, samp[COEF_W-1:0]});
    end
    prod_lo = m_a * m_b;
    prod_hi = coef * signed'(samp[SAMP_W-1:COEF_W]);
    t_sum = (T_W'(acc_hi_q) <<< COEF_W) + T_W'(acc_lo_q);
    y_new = SAMP_W'(clip(t_sum >>> FRAC_BITS, SAMP_W));
    prod_rnd = (prod_q + RND_PROD) >>> FRAC_BITS;
    row_sum = (SAMP_W + 1)'(row_rd_q) + (SAMP_W + 1)'(res_q);
    col_sum = (SAMP_W + 2)'(col_rd_q) + (SAMP_W + 2)'(res_q) + RND_SUM;
    row_wd = anti_q ? SAMP_W'(clip(T_W'(row_sum), SAMP_W)) : res_q;
    grad_wd = GRAD_W'(clip(T_W'(col_sum >>> FRAC_BITS), GRAD_W));
    n_len = colpass_q ? LW'(height_i) : LW'(width_i);
    n_lines = colpass_q ? LW'(width_i) : LW'(height_i);
    last_step = (j_q == n_len - LW'(1));
    last_line = (line_q == n_lines - LW'(1));
    stride = colpass_q ? AW'(width_i) : AW'(1);
    lstride = colpass_q ? AW'(1) : AW'(width_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (go_i) begin
          state_d = CS_PREP0;
        end
      end
      CS_PREP0: state_d = CS_PREP1;
      CS_PREP1: state_d = CS_PREP2;
      CS_PREP2: state_d = CS_READ;
      CS_READ: state_d = CS_MAC;
      CS_MAC: begin
        if (k_q == 2'd3) begin
          state_d = CS_FIN;
        end
      end
      CS_FIN: state_d = CS_WB;
      CS_WB: begin
        if (last_step && anti_q && last_line && colpass_q && phase_q) begin
          state_d = CS_IDLE;
        end else begin
          state_d = CS_READ;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    row_we = 1'b0;
    col_we = 1'b0;
    gdn_we = 1'b0;
    gac_we = 1'b0;
    case (state_q)
      CS_WB: begin
        row_we = ~colpass_q;
        col_we = colpass_q & ~anti_q;
        gdn_we = colpass_q & anti_q & ~phase_q;
        gac_we = colpass_q & anti_q & phase_q;
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
    busy_o = (state_q != CS_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      phase_q <= 1'b0;
      colpass_q <= 1'b0;
      anti_q <= 1'b0;
      k_q <= '0;
      line_q <= '0;
      j_q <= '0;
      base_q <= '0;
      addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == CS_IDLE && go_i) begin
        phase_q <= 1'b0;
        colpass_q <= 1'b0;
        anti_q <= 1'b0;
        line_q <= '0;
        j_q <= '0;
        base_q <= '0;
        addr_q <= '0;
      end
      if (state_q == CS_READ) begin
        k_q <= '0;
      end
      if (state_q == CS_MAC) begin
        k_q <= k_q + 2'd1;
      end
      if (state_q == CS_WB) begin
        if (!last_step) begin
          j_q <= j_q + LW'(1);
          addr_q <= anti_q ? addr_q - stride : addr_q + stride;
        end else if (!anti_q) begin
          anti_q <= 1'b1;
          j_q <= '0;
        end else begin
          anti_q <= 1'b0;
          j_q <= '0;
          if (!last_line) begin
            line_q <= line_q + LW'(1);
            base_q <= base_q + lstride;
            addr_q <= base_q + lstride;
          end else begin
            line_q <= '0;
            base_q <= '0;
            addr_q <= '0;
            if (!colpass_q) begin
              colpass_q <= 1'b1;
            end else begin
              colpass_q <= 1'b0;
              phase_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_PREP0: begin
        prod_q <= prod_lo;
      end
      CS_PREP1: begin
        a3_q <= COEF_W'(clip(T_W'(coef_i.smooth_b) - T_W'(prod_rnd), COEF_W));
        prod_q <= prod_lo;
      end
      CS_PREP2: begin
        a4_q <= COEF_W'(clip(-T_W'(prod_rnd), COEF_W));
        xa_q <= '0;
        xb_q <= '0;
        ya_q <= '0;
        yb_q <= '0;
      end
      CS_MAC: begin
        acc_lo_q <= ((k_q == 2'd0) ? RND_ACC : acc_lo_q) + AL_W'(prod_lo);
        acc_hi_q <= ((k_q == 2'd0) ? AH_W'(0) : acc_hi_q) + AH_W'(prod_hi);
      end
      CS_FIN: begin
        res_q <= y_new;
        xb_q <= xa_q;
        xa_q <= fetch;
        yb_q <= ya_q;
        ya_q <= y_new;
      end
      CS_WB: begin
        if (last_step) begin
          xa_q <= '0;
          xb_q <= '0;
          ya_q <= '0;
          yb_q <= '0;
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

endmodule

// ----- tb/tb_deriche_gradient_filter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of deriche_gradient_filter: frame loads, result pulls and APB setup,
// checked against a bit-exact gradient predictor kept in a scoreboard class.
// Depends on dgf_pkg and the deriche_gradient_filter RTL.
module tb_deriche_gradient_filter;
  import dgf_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;
  localparam int NPIX = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam longint MAX48 = 64'sd140737488355327;
  localparam longint MIN48 = -64'sd140737488355328;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [GRAD_W-1:0] down;
    logic signed [GRAD_W-1:0] across;
    logic                     last;
    status_e                  status;
  } grad_result_t;

  class gradient_scoreboard;
    grad_result_t expected_q[$];
    int unsigned mismatches;
    logic [31:0] regs[7];
    int unsigned lat_w, lat_h, load_n, read_n;
    bit ready;
    longint fb1, fb2;
    logic [PIX_W-1:0] pix_mem[NPIX];
    longint row_mem[NPIX];
    longint col_mem[NPIX];
    logic signed [GRAD_W-1:0] down_mem[NPIX];
    logic signed [GRAD_W-1:0] across_mem[NPIX];

    function new();
      regs[REG_WIDTH] = CFG_SIZE_RESET;
      regs[REG_HEIGHT] = CFG_SIZE_RESET;
      for (int i = REG_SMOOTH_A; i <= REG_FB_TWO; i++) regs[i] = 0;
      lat_w = DEF_MAX_WIDTH;
      lat_h = DEF_MAX_HEIGHT;
      load_n = 0;
      read_n = 0;
      ready = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] v);
      if (idx == REG_WIDTH || idx == REG_HEIGHT) regs[idx] = v & 32'h1FF;
      else regs[idx] = v & 32'hFF_FFFF;
    endfunction

    function int unsigned eff_size(logic [31:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function longint sext24(logic [31:0] v);
      logic signed [23:0] s;
      s = v[23:0];
      return longint'(s);
    endfunction

    function longint round_frac(longint x);
      return (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function longint sat(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function longint mac4(longint a[4], longint v[4]);
      logic signed [127:0] acc, ta, tv;
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        ta = a[k];
        tv = v[k];
        acc += ta * tv;
      end
      acc = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (acc > MAX48) return MAX48;
      if (acc < MIN48) return MIN48;
      return longint'(acc);
    endfunction

    function longint sample(bit from_rows, int unsigned i);
      if (!from_rows) return longint'({1'b0, pix_mem[i]}) <<< FRAC;
      return row_mem[i];
    endfunction

    function void causal_pass(bit from_rows, int unsigned first, int unsigned stride,
                              int unsigned n, longint c0, longint c1);
      longint a[4], v[4];
      longint x, y, xp, y1, y2;
      int unsigned i;
      a = '{c0, c1, -fb1, -fb2};
      xp = 0; y1 = 0; y2 = 0;
      for (int unsigned j = 0; j < n; j++) begin
        i = first + j * stride;
        x = sample(from_rows, i);
        v = '{x, xp, y1, y2};
        y = mac4(a, v);
        if (from_rows) col_mem[i] = y;
        else row_mem[i] = y;
        xp = x; y2 = y1; y1 = y;
      end
    endfunction

    function void anticausal_pass(bit from_rows, int unsigned first, int unsigned stride,
                                  int unsigned n, longint d1, longint d2, int sink);
      longint a[4], v[4];
      longint z, g, x1, x2, z1, z2;
      int unsigned i;
      a = '{d1, d2, -fb1, -fb2};
      x1 = 0; x2 = 0; z1 = 0; z2 = 0;
      for (int unsigned j = n; j > 0; j--) begin
        i = first + (j - 1) * stride;
        v = '{x1, x2, z1, z2};
        z = mac4(a, v);
        x2 = x1; x1 = sample(from_rows, i);
        z2 = z1; z1 = z;
        if (sink == 0) begin
          row_mem[i] = sat(row_mem[i] + z, MIN48, MAX48);
        end else begin
          g = sat(round_frac(col_mem[i] + z), -64'sd2147483648, 64'sd2147483647);
          if (sink == 1) down_mem[i] = g[31:0];
          else across_mem[i] = g[31:0];
        end
      end
    endfunction

    function void compute_gradients();
      longint a1, a2, k, a3, a4;
      longint rc0, rc1, rd1, rd2, cc0, cc1, cd1, cd2;
      a1 = sext24(regs[REG_SMOOTH_A]);
      a2 = sext24(regs[REG_SMOOTH_B]);
      k = sext24(regs[REG_DERIV]);
      fb1 = sext24(regs[REG_FB_ONE]);
      fb2 = sext24(regs[REG_FB_TWO]);
      a3 = sat(a2 - round_frac(a1 * fb1), -64'sd8388608, 64'sd8388607);
      a4 = sat(-round_frac(a1 * fb2), -64'sd8388608, 64'sd8388607);
      for (int p = 0; p < 2; p++) begin
        rc0 = p ? 0 : a1;  rc1 = p ? k : a2;
        rd1 = p ? -k : a3; rd2 = p ? 0 : a4;
        cc0 = p ? a1 : 0;  cc1 = p ? a2 : k;
        cd1 = p ? a3 : -k; cd2 = p ? a4 : 0;
        for (int unsigned r = 0; r < lat_h; r++) begin
          causal_pass(0, r * lat_w, 1, lat_w, rc0, rc1);
          anticausal_pass(0, r * lat_w, 1, lat_w, rd1, rd2, 0);
        end
        for (int unsigned c = 0; c < lat_w; c++) begin
          causal_pass(1, c, lat_w, lat_h, cc0, cc1);
          anticausal_pass(1, c, lat_w, lat_h, cd1, cd2, p + 1);
        end
      end
    endfunction

    function void note_transaction(logic mode, logic [PIX_W-1:0] pix);
      grad_result_t res;
      int unsigned total, w, h;
      if (mode == 1'b0) begin
        if (ready) begin
          ready = 0; load_n = 0; read_n = 0;
        end
        if (load_n == 0) begin
          lat_w = eff_size(regs[REG_WIDTH], DEF_MAX_WIDTH);
          lat_h = eff_size(regs[REG_HEIGHT], DEF_MAX_HEIGHT);
        end
        total = lat_w * lat_h;
        if (load_n < total) begin
          pix_mem[load_n] = pix;
          load_n++;
        end
        if (load_n >= total) begin
          if (lat_w >= 2 && lat_h >= 2) begin
            compute_gradients();
            ready = 1;
            read_n = 0;
          end else begin
            load_n = 0;
          end
        end
        return;
      end
      res = '{down: 0, across: 0, last: 0, status: STAT_OK};
      if (ready) begin
        total = lat_w * lat_h;
        res.down = down_mem[read_n];
        res.across = across_mem[read_n];
        res.last = (read_n + 1 == total);
        read_n++;
        if (read_n >= total) begin
          ready = 0; load_n = 0; read_n = 0;
        end
      end else begin
        w = load_n ? lat_w : eff_size(regs[REG_WIDTH], DEF_MAX_WIDTH);
        h = load_n ? lat_h : eff_size(regs[REG_HEIGHT], DEF_MAX_HEIGHT);
        res.status = (w < 2 || h < 2) ? STAT_SMALL : STAT_PENDING;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(grad_result_t act);
      grad_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: down %0d across %0d status %0d",
                                       act.down, act.across, act.status);
        return;
      end
      exp_r = expected_q.pop_front();
      if (act.down !== exp_r.down || act.across !== exp_r.across ||
          act.last !== exp_r.last || act.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected down %0d across %0d last %0d status %0d, got %0d %0d %0d %0d",
                   exp_r.down, exp_r.across, exp_r.last, exp_r.status,
                   act.down, act.across, act.last, act.status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic mode_i = 1'b0;
  logic [PIX_W-1:0] pixel_i = '0;
  logic done_o;
  logic signed [GRAD_W-1:0] deriv_down_o, deriv_across_o;
  logic last_o;
  logic [1:0] status_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  gradient_scoreboard sb = new();
  longint cycles = 0;
  int unsigned items = 0;
  int unsigned idle_pct = 0;
  int unsigned cur_w = DEF_MAX_WIDTH, cur_h = DEF_MAX_HEIGHT;

  deriche_gradient_filter i_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .pixel_i, .done_o, .deriv_down_o,
    .deriv_across_o, .last_o, .status_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL deriche_gradient_filter");
      $finish;
    end
    if (rst_ni) begin
      if (done_o)
        sb.check_result('{down: deriv_down_o, across: deriv_across_o, last: last_o,
                          status: status_e'(status_o)});
      if (start && !busy) sb.note_transaction(mode_i, pixel_i);
    end
  end

  task automatic issue(logic mode, logic [PIX_W-1:0] pix);
    if (idle_pct != 0) begin
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk_i) start <= 1'b0;
      end
    end
    @(negedge clk_i);
    start <= 1'b1;
    mode_i <= mode;
    pixel_i <= pix;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    items++;
  endtask

  task automatic drain();
    @(negedge clk_i) start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_WIDTH) cur_w = sb.eff_size(v & 32'h1FF, DEF_MAX_WIDTH);
    if (idx == REG_HEIGHT) cur_h = sb.eff_size(v & 32'h1FF, DEF_MAX_HEIGHT);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h007F_FFFF : 32'hFF80_0000;
      default: return $urandom_range(131071) - 65536;
    endcase
  endfunction

  task automatic random_setup();
    int unsigned w, h;
    w = ($urandom_range(9) == 0) ? $urandom_range(10, 2) : $urandom_range(5, 2);
    h = ($urandom_range(9) == 0) ? $urandom_range(10, 2) : $urandom_range(5, 2);
    if ($urandom_range(19) == 0) begin
      if ($urandom_range(1)) w = $urandom_range(1);
      else h = $urandom_range(1);
    end
    set_reg(REG_WIDTH, {$urandom() & 32'hFFFF_FE00} | w);
    set_reg(REG_HEIGHT, h);
    for (int i = REG_SMOOTH_A; i <= REG_FB_TWO; i++)
      if ($urandom_range(2) != 0) set_reg(reg_idx_e'(i), rand_gain());
  endtask

  task automatic random_frame();
    int unsigned total;
    total = cur_w * cur_h;
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(99) < 8) issue(1'b1, $urandom());
      issue(1'b0, $urandom());
    end
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(99) < 2) issue(1'b0, $urandom());
      issue(1'b1, $urandom());
    end
    if ($urandom_range(2) == 0) issue(1'b1, $urandom());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    issue(1'b1, 16'h0000);
    drain();
    set_reg(REG_WIDTH, 0);
    set_reg(REG_HEIGHT, 3);
    issue(1'b1, 16'hFFFF);
    issue(1'b0, 16'hFFFF);
    issue(1'b0, 16'h0000);
    issue(1'b1, 16'h0000);
    issue(1'b0, 16'h1234);
    issue(1'b1, 16'h0000);
    drain();
    set_reg(REG_WIDTH, 32'h1FF);
    set_reg(REG_HEIGHT, 32'h1FF);
    issue(1'b1, 16'h0000);
    drain();
    set_reg(REG_WIDTH, 2);
    set_reg(REG_HEIGHT, 2);
    set_reg(REG_SMOOTH_A, 32'h007F_FFFF);
    set_reg(REG_SMOOTH_B, 32'h0080_0000);
    set_reg(REG_DERIV, 32'h007F_FFFF);
    set_reg(REG_FB_ONE, 32'h0080_0000);
    set_reg(REG_FB_TWO, 32'h007F_FFFF);
    issue(1'b0, 16'h0000);
    issue(1'b1, 16'h0000);
    issue(1'b0, 16'hFFFF);
    issue(1'b0, 16'hFFFF);
    issue(1'b0, 16'h0000);
    repeat (5) issue(1'b1, 16'h0000);
    drain();
    set_reg(REG_SMOOTH_A, 32'h0000_8000);
    set_reg(REG_SMOOTH_B, 32'hFFFF_C000);
    set_reg(REG_FB_ONE, 32'hFFFF_0000);
    set_reg(REG_FB_TWO, 32'h0000_4000);
    repeat (4) issue(1'b0, $urandom());
    issue(1'b1, 16'h0000);
    issue(1'b0, 16'hABCD);
    issue(1'b1, 16'h0000);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 37 : (phase == 1) ? 57 : 0;
      while (items < 25 + 250 * (phase + 1)) begin
        random_setup();
        repeat ($urandom_range(3, 1)) random_frame();
        drain();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS deriche_gradient_filter");
    end else begin
      $display("FAIL deriche_gradient_filter");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/dgf_pkg.sv
design/dgf_core.sv
design/deriche_gradient_filter.sv
tb/tb_deriche_gradient_filter.sv
